// ----- hdl/whe_pkg.sv -----
// ----------------------------------------------------------------------------
// whe_pkg
// Shared types and constants of the windowed heading estimator.
// ----------------------------------------------------------------------------
package whe_pkg;

    localparam int WINDOW_INTERVALS = 15;
    localparam int FILL_W   = $clog2(WINDOW_INTERVALS + 1);
    // signed interval quotient, magnitude below 2^32
    localparam int QUOT_W   = 34;
    localparam int SUM_W    = QUOT_W + $clog2(WINDOW_INTERVALS + 1);
    localparam int DIVN_W   = 48;
    localparam int DIVD_W   = 32;
    localparam int DCNT_W   = $clog2(DIVN_W + 1);
    localparam int UNIT_Q14 = 16384;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } whe_div_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DIVN_W-1:0] quotient;
    } whe_div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] radicand;
    } whe_sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } whe_sqrt_rsp_t;

endpackage

// ----- hdl/whe_div.sv -----
// ----------------------------------------------------------------------------
// whe_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module whe_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  whe_pkg::whe_div_req_t req,
    output whe_pkg::whe_div_rsp_t rsp
);
    import whe_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVN_W-1:0] q_reg, q_next;
    logic [DIVD_W-1:0] dsr_reg, dsr_next;
    logic [DIVD_W:0]   rem_shift;

    // one restoring step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        rem_shift = {rem_reg, q_reg[DIVN_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, dsr_reg}) begin
                rem_next = DIVD_W'(rem_shift - {1'b0, dsr_reg});
                q_next   = {q_reg[DIVN_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIVD_W-1:0];
                q_next   = {q_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIVN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = q_reg;

endmodule

// ----- hdl/whe_isqrt.sv -----
// ----------------------------------------------------------------------------
// whe_isqrt
// Integer square root, one bit pair per cycle.
// ----------------------------------------------------------------------------
module whe_isqrt (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  whe_pkg::whe_sqrt_req_t req,
    output whe_pkg::whe_sqrt_rsp_t rsp
);
    import whe_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    // digit-by-digit root step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        trial     = r_reg + bit_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = req.radicand;
            r_next    = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = r_reg[31:0];

endmodule

// ----- hdl/windowed_heading_estimator_top.sv -----
// ----------------------------------------------------------------------------
// windowed_heading_estimator_top
// Sliding-window velocity heading of one tracked object.
// ----------------------------------------------------------------------------
// Each position sample yields one result. The velocity quotient of the newest
// interval is found once per sample and kept in a line of the last
// WINDOW_INTERVALS quotients with a running sum. Before the window is full an
// item takes two 48-step divisions; once full it takes two interval divisions,
// up to 29 normalising shifts, two squarings, a 32-step square root and two
// heading divisions, all on one shared divider and root unit. The first sample
// and a sample with no time difference skip the interval divisions. The input
// is ready only while the sequencer is idle; a result waits in an output register.
module windowed_heading_estimator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pos_x[15:0], pos_y[31:16], time_ticks[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // head_x[15:0], head_y[31:16]
    output logic [1:0]  m_tuser    // updated[0], zero_interval[1]
);
    import whe_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0,  S_QX   = 4'd1,  S_QXW  = 4'd2,
                           S_QY    = 4'd3,  S_QYW  = 4'd4,  S_ACC  = 4'd5,
                           S_NORM  = 4'd6,  S_SQX  = 4'd7,  S_SQY  = 4'd8,
                           S_SQRT  = 4'd9,  S_SQRTW = 4'd10, S_HX  = 4'd11,
                           S_HXW   = 4'd12, S_HY   = 4'd13, S_HYW  = 4'd14,
                           S_DONE  = 4'd15;

    logic [3:0]               state_reg, state_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [FILL_W-1:0]        qcnt_reg, qcnt_next;
    logic signed [15:0]       prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [31:0]              prev_t_reg, prev_t_next;
    logic signed [16:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]              dt_reg, dt_next;
    logic signed [QUOT_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [QUOT_W-1:0] line_x_reg [WINDOW_INTERVALS];
    logic signed [QUOT_W-1:0] line_y_reg [WINDOW_INTERVALS];
    logic [WINDOW_INTERVALS-1:0] line_z_reg, line_z_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [SUM_W-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic [63:0]              sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [31:0]              root_reg, root_next;
    logic [15:0]              mx_reg, mx_next;
    logic signed [15:0]       held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic                     upd_reg, upd_next;
    logic                     m_valid_reg, m_valid_next;
    logic [31:0]              m_data_reg, m_data_next;
    logic [1:0]               m_user_reg, m_user_next;
    logic                     shift_en;
    logic [SUM_W-1:0]         mag_max;
    logic [16:0]              abs_d;
    logic [DIVN_W-1:0]        q_clip;
    whe_div_req_t             div_req;
    whe_div_rsp_t             div_rsp;
    whe_sqrt_req_t            sqrt_req;
    whe_sqrt_rsp_t            sqrt_rsp;

    whe_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));
    whe_isqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .req(sqrt_req), .rsp(sqrt_rsp));

    assign s_tready = (state_reg == S_IDLE);
    assign mag_max  = (ax_reg > ay_reg) ? ax_reg : ay_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        qcnt_next    = qcnt_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        prev_t_next  = prev_t_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dt_next      = dt_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        line_z_next  = line_z_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        root_next    = root_reg;
        mx_next      = mx_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        upd_next     = upd_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        shift_en     = 1'b0;
        abs_d        = '0;
        q_clip       = '0;
        div_req      = '0;
        sqrt_req     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    prev_x_next = s_tdata[15:0];
                    prev_y_next = s_tdata[31:16];
                    prev_t_next = s_tdata[63:32];
                    dx_next = 17'(signed'(s_tdata[15:0])) - 17'(prev_x_reg);
                    dy_next = 17'(signed'(s_tdata[31:16])) - 17'(prev_y_reg);
                    dt_next = s_tdata[63:32] - prev_t_reg;
                    upd_next = 1'b0;
                    if (fill_reg == '0) begin
                        fill_next  = FILL_W'(1);
                        state_next = S_DONE;
                    end else begin
                        state_next = S_QX;
                    end
                end
            end
            S_QX: begin
                if (dt_reg == '0) begin
                    qx_next = '0;
                    qy_next = '0;
                    state_next = S_ACC;
                end else begin
                    abs_d = dx_reg[16] ? 17'(-dx_reg) : dx_reg;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVN_W'({abs_d, 16'b0});
                    div_req.divisor  = dt_reg;
                    state_next = S_QXW;
                end
            end
            S_QXW: begin
                if (div_rsp.done) begin
                    qx_next = dx_reg[16] ? -QUOT_W'(div_rsp.quotient)
                                         : QUOT_W'(div_rsp.quotient);
                    state_next = S_QY;
                end
            end
            S_QY: begin
                abs_d = dy_reg[16] ? 17'(-dy_reg) : dy_reg;
                div_req.start    = 1'b1;
                div_req.dividend = DIVN_W'({abs_d, 16'b0});
                div_req.divisor  = dt_reg;
                state_next = S_QYW;
            end
            S_QYW: begin
                if (div_rsp.done) begin
                    qy_next = dy_reg[16] ? -QUOT_W'(div_rsp.quotient)
                                         : QUOT_W'(div_rsp.quotient);
                    state_next = S_ACC;
                end
            end
            // slide the window: add the newest interval, drop the oldest once the window is full
            S_ACC: begin
                shift_en = 1'b1;
                line_z_next = {line_z_reg[WINDOW_INTERVALS-2:0], (dt_reg == '0)};
                if (qcnt_reg == FILL_W'(WINDOW_INTERVALS)) begin
                    sum_x_next = sum_x_reg + SUM_W'(qx_reg)
                               - SUM_W'(line_x_reg[WINDOW_INTERVALS-1]);
                    sum_y_next = sum_y_reg + SUM_W'(qy_reg)
                               - SUM_W'(line_y_reg[WINDOW_INTERVALS-1]);
                end else begin
                    sum_x_next = sum_x_reg + SUM_W'(qx_reg);
                    sum_y_next = sum_y_reg + SUM_W'(qy_reg);
                    qcnt_next  = qcnt_reg + 1'b1;
                end
                if (fill_reg != FILL_W'(WINDOW_INTERVALS)) begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = S_DONE;
                end else begin
                    upd_next   = 1'b1;
                    ax_next    = sum_x_next[SUM_W-1] ? SUM_W'(-sum_x_next) : sum_x_next;
                    ay_next    = sum_y_next[SUM_W-1] ? SUM_W'(-sum_y_next) : sum_y_next;
                    state_next = S_NORM;
                end
            end
            // scale both magnitudes until the larger lies in [2^29, 2^30); a zero sum gives heading (1, 0)
            S_NORM: begin
                if (mag_max == '0) begin
                    held_x_next = 16'(UNIT_Q14);
                    held_y_next = '0;
                    state_next  = S_DONE;
                end else if (mag_max >= SUM_W'(1 << 30)) begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                end else if (mag_max < SUM_W'(1 << 29)) begin
                    ax_next = ax_reg << 1;
                    ay_next = ay_reg << 1;
                end else begin
                    state_next = S_SQX;
                end
            end
            S_SQX: begin
                sqx_next   = 64'(ax_reg[29:0] * ax_reg[29:0]);
                state_next = S_SQY;
            end
            S_SQY: begin
                sqy_next   = 64'(ay_reg[29:0] * ay_reg[29:0]);
                state_next = S_SQRT;
            end
            S_SQRT: begin
                sqrt_req.start    = 1'b1;
                sqrt_req.radicand = sqx_reg + sqy_reg;
                state_next = S_SQRTW;
            end
            S_SQRTW: begin
                if (sqrt_rsp.done) begin
                    root_next  = sqrt_rsp.root;
                    state_next = S_HX;
                end
            end
            S_HX: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVN_W'({ax_reg[29:0], 14'b0}) + DIVN_W'(root_reg >> 1);
                div_req.divisor  = root_reg;
                state_next = S_HXW;
            end
            S_HXW: begin
                if (div_rsp.done) begin
                    q_clip  = (div_rsp.quotient > DIVN_W'(UNIT_Q14)) ? DIVN_W'(UNIT_Q14)
                                                                    : div_rsp.quotient;
                    mx_next = q_clip[15:0];
                    state_next = S_HY;
                end
            end
            S_HY: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVN_W'({ay_reg[29:0], 14'b0}) + DIVN_W'(root_reg >> 1);
                div_req.divisor  = root_reg;
                state_next = S_HYW;
            end
            S_HYW: begin
                if (div_rsp.done) begin
                    q_clip  = (div_rsp.quotient > DIVN_W'(UNIT_Q14)) ? DIVN_W'(UNIT_Q14)
                                                                    : div_rsp.quotient;
                    held_x_next = sum_x_reg[SUM_W-1] ? -signed'(mx_reg) : signed'(mx_reg);
                    held_y_next = sum_y_reg[SUM_W-1] ? -signed'(q_clip[15:0])
                                                     : signed'(q_clip[15:0]);
                    state_next = S_DONE;
                end
            end
            // hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {held_y_reg, held_x_reg};
                    m_user_next  = {upd_reg && (line_z_reg != '0), upd_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            qcnt_reg    <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            m_valid_reg <= 1'b0;
            upd_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            qcnt_reg    <= qcnt_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            held_x_reg  <= held_x_next;
            held_y_reg  <= held_y_next;
            m_valid_reg <= m_valid_next;
            upd_reg     <= upd_next;
        end
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        prev_t_reg <= prev_t_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dt_reg     <= dt_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        line_z_reg <= line_z_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        root_reg   <= root_next;
        mx_reg     <= mx_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // quotient line, newest at tap zero
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            line_x_reg[0] <= qx_reg;
            line_y_reg[0] <= qy_reg;
            for (int i = 1; i < WINDOW_INTERVALS; i++) begin
                line_x_reg[i] <= line_x_reg[i-1];
                line_y_reg[i] <= line_y_reg[i-1];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // the divider is never restarted while still busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // a held result never carries the zero interval flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> !m_tuser[1])
        else $error("zero interval flag on held result");

    // heading components stay within one in Q2.14
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 &&
                      $signed(m_tdata[15:0]) >= -16'sd16384 &&
                      $signed(m_tdata[31:16]) <= 16'sd16384 &&
                      $signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("heading component out of range");

    // the window count never passes its end
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW_INTERVALS) && qcnt_reg <= fill_reg)
        else $error("window count out of range");

endmodule
